[hdl/bple_pkg.sv]
// Package with the shared types, constants and command codes of the list engine.
package bple_pkg;
  localparam int Capacity = 64;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    MODE_INSERT = 4'd0,
    MODE_DELETE = 4'd1,
    MODE_UPDATE = 4'd2,
    MODE_GET = 4'd3,
    MODE_LOCATE = 4'd4,
    MODE_LENGTH = 4'd5,
    MODE_REVERSE = 4'd6,
    MODE_SORT = 4'd7,
    MODE_CLEAR = 4'd8
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_WR,
    ST_FETCH,
    ST_GRAB,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_LOC_RD,
    ST_LOC_CMP,
    ST_REV_RD_A,
    ST_REV_RD_B,
    ST_REV_WR_A,
    ST_REV_WR_B,
    ST_SORT_LD,
    ST_SORT_FIRST,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_END,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic [2:0] rd_sel;
    logic wr;
    logic [2:0] wr_sel;
    logic [1:0] hold_sel;
    logic [2:0] step;
    logic [2:0] fin;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic valid_pos;
    logic can_insert;
    logic multi;
    logic ins_more;
    logic ins_again;
    logic del_more;
    logic del_again;
    logic loc_start;
    logic loc_again;
    logic loc_hit;
    logic rev_again;
    logic sort_swap;
    logic sort_again;
    logic pass_again;
  } stat_t;

  localparam logic [2:0] RD_K = 3'd0, RD_KM1 = 3'd1, RD_KP1 = 3'd2, RD_J = 3'd3,
                         RD_JP1 = 3'd4;
  localparam logic [2:0] WR_K_RDATA = 3'd0, WR_J_HOLD = 3'd1, WR_J_MIN = 3'd2,
                         WR_LAST = 3'd3, WR_VAL = 3'd4;
  localparam logic [1:0] HOLD_KEEP = 2'd0, HOLD_RDATA = 2'd1, HOLD_MAX = 2'd2;
  localparam logic [2:0] STEP_NONE = 3'd0, STEP_K_DEC = 3'd1, STEP_K_INC = 3'd2,
                         STEP_REV = 3'd3, STEP_J_INC = 3'd4, STEP_PASS = 3'd5;
  localparam logic [2:0] FIN_NONE = 3'd0, FIN_OK = 3'd1, FIN_FAIL = 3'd2,
                         FIN_INS = 3'd3, FIN_DEL = 3'd4, FIN_GET = 3'd5,
                         FIN_CLEAR = 3'd6, FIN_LOC = 3'd7;
endpackage

[hdl/bple_if.sv]
// Handshake channel interfaces for commands and results.
interface bple_cmd_if import bple_pkg::*; ();
  logic valid;
  logic ready;
  logic [3:0] mode;
  logic [7:0] position;
  logic signed [31:0] value;
  modport source(output valid, mode, position, value, input ready);
  modport sink(input valid, mode, position, value, output ready);
  modport monitor(input valid, ready, mode, position, value);
endinterface

interface bple_res_if import bple_pkg::*; ();
  logic valid;
  logic ready;
  logic ok;
  logic signed [31:0] data;
  logic [6:0] index;
  modport source(output valid, ok, data, index, input ready);
  modport sink(input valid, ok, data, index, output ready);
  modport monitor(input valid, ready, ok, data, index);
endinterface

[hdl/bple_datapath.sv]
// Datapath: entry memory, count, walk pointers and result registers.
module bple_datapath import bple_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output stat_t stat,
  input  logic [3:0] in_mode,
  input  logic [7:0] in_position,
  input  logic signed [31:0] in_value,
  output logic res_ok,
  output logic signed [31:0] res_data,
  output logic [6:0] res_index
);
  logic [31:0] mem [Capacity];
  logic [31:0] rdata;
  logic [31:0] hold;
  logic [3:0] mode;
  logic [7:0] position;
  logic [31:0] value;
  logic [CountW-1:0] count;
  logic [CountW-1:0] k;
  logic [CountW-1:0] j;
  logic [CountW-1:0] lim;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  logic [31:0] wdata;

  always_comb begin
    stat.mode = mode;
    stat.valid_pos = (position != 8'd0) && (position <= 8'(count));
    stat.can_insert = (position != 8'd0) && (position <= 8'(count) + 8'd1)
                      && (count < CountW'(Capacity));
    stat.multi = count > CountW'(1);
    stat.ins_more = 8'(k) >= position;
    stat.ins_again = 8'(k) > position;
    stat.del_more = (k + CountW'(1)) < count;
    stat.del_again = (k + CountW'(2)) < count;
    stat.loc_start = 8'(count) > position;
    stat.loc_again = (k + CountW'(1)) < count;
    stat.loc_hit = rdata == value;
    stat.rev_again = (k + CountW'(2)) < j;
    stat.sort_swap = $signed(hold) > $signed(rdata);
    stat.sort_again = (j + CountW'(2)) < lim;
    stat.pass_again = lim > CountW'(2);
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_K: raddr = k[AddrW-1:0];
      RD_KM1: raddr = AddrW'(k - CountW'(1));
      RD_KP1: raddr = AddrW'(k + CountW'(1));
      RD_J: raddr = j[AddrW-1:0];
      RD_JP1: raddr = AddrW'(j + CountW'(1));
      default: raddr = k[AddrW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_K_RDATA: begin
        waddr = k[AddrW-1:0];
        wdata = rdata;
      end
      WR_J_HOLD: begin
        waddr = j[AddrW-1:0];
        wdata = hold;
      end
      WR_J_MIN: begin
        waddr = j[AddrW-1:0];
        wdata = stat.sort_swap ? rdata : hold;
      end
      WR_LAST: begin
        waddr = AddrW'(lim - CountW'(1));
        wdata = hold;
      end
      WR_VAL: begin
        waddr = AddrW'(position - 8'd1);
        wdata = value;
      end
      default: begin
        waddr = k[AddrW-1:0];
        wdata = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[raddr];
    end
    if (cmd.wr) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.load) begin
        mode <= in_mode;
        position <= in_position;
        value <= in_value;
        lim <= count;
        unique case (in_mode)
          MODE_INSERT: k <= count;
          MODE_LOCATE: k <= CountW'(in_position);
          MODE_REVERSE, MODE_SORT: k <= '0;
          default: k <= CountW'(in_position - 8'd1);
        endcase
        if (in_mode == MODE_REVERSE) begin
          j <= count - CountW'(1);
        end else begin
          j <= '0;
        end
      end else begin
        unique case (cmd.step)
          STEP_NONE: ;
          STEP_K_DEC: k <= k - CountW'(1);
          STEP_K_INC: k <= k + CountW'(1);
          STEP_REV: begin
            k <= k + CountW'(1);
            j <= j - CountW'(1);
          end
          STEP_J_INC: j <= j + CountW'(1);
          STEP_PASS: begin
            j <= '0;
            lim <= lim - CountW'(1);
          end
          default: ;
        endcase
      end
      unique case (cmd.hold_sel)
        HOLD_KEEP: ;
        HOLD_RDATA: hold <= rdata;
        HOLD_MAX: hold <= stat.sort_swap ? hold : rdata;
        default: ;
      endcase
      unique case (cmd.fin)
        FIN_NONE: ;
        FIN_OK: begin
          res_ok <= 1'b1;
          res_data <= '0;
          res_index <= 7'(count);
        end
        FIN_FAIL: begin
          res_ok <= 1'b0;
          res_data <= '0;
          res_index <= (mode == MODE_LOCATE) ? 7'd0 : 7'(count);
        end
        FIN_INS: begin
          res_ok <= 1'b1;
          res_data <= '0;
          res_index <= 7'(count + CountW'(1));
          count <= count + CountW'(1);
        end
        FIN_DEL: begin
          res_ok <= 1'b1;
          res_data <= hold;
          res_index <= 7'(count - CountW'(1));
          count <= count - CountW'(1);
        end
        FIN_GET: begin
          res_ok <= 1'b1;
          res_data <= hold;
          res_index <= 7'(count);
        end
        FIN_CLEAR: begin
          res_ok <= 1'b1;
          res_data <= '0;
          res_index <= 7'd0;
          count <= '0;
        end
        FIN_LOC: begin
          res_ok <= 1'b1;
          res_data <= '0;
          res_index <= 7'(k + CountW'(1));
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Capacity));
  a_load_alone: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && (cmd.step != STEP_NONE)));
endmodule

[hdl/bple_ctrl.sv]
// Controller state machine sequencing each command over the datapath.
module bple_ctrl import bple_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  stat_t stat,
  output cmd_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        unique case (stat.mode)
          MODE_INSERT: state_next = (stat.can_insert && stat.ins_more) ? ST_INS_RD : ST_DONE;
          MODE_DELETE, MODE_GET: state_next = stat.valid_pos ? ST_FETCH : ST_DONE;
          MODE_LOCATE: state_next = stat.loc_start ? ST_LOC_RD : ST_DONE;
          MODE_REVERSE: state_next = stat.multi ? ST_REV_RD_A : ST_DONE;
          MODE_SORT: state_next = stat.multi ? ST_SORT_LD : ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_INS_RD: state_next = ST_INS_WR;
      ST_INS_WR: state_next = stat.ins_again ? ST_INS_RD : ST_DONE;
      ST_FETCH: state_next = ST_GRAB;
      ST_GRAB: state_next = (stat.mode == MODE_DELETE && stat.del_more) ? ST_DEL_RD : ST_DONE;
      ST_DEL_RD: state_next = ST_DEL_WR;
      ST_DEL_WR: state_next = stat.del_again ? ST_DEL_RD : ST_DONE;
      ST_LOC_RD: state_next = ST_LOC_CMP;
      ST_LOC_CMP: state_next = stat.loc_hit ? ST_OUT : (stat.loc_again ? ST_LOC_RD : ST_DONE);
      ST_REV_RD_A: state_next = ST_REV_RD_B;
      ST_REV_RD_B: state_next = ST_REV_WR_A;
      ST_REV_WR_A: state_next = ST_REV_WR_B;
      ST_REV_WR_B: state_next = stat.rev_again ? ST_REV_RD_A : ST_DONE;
      ST_SORT_LD: state_next = ST_SORT_FIRST;
      ST_SORT_FIRST: state_next = ST_SORT_CMP;
      ST_SORT_CMP: state_next = stat.sort_again ? ST_SORT_RD : ST_SORT_END;
      ST_SORT_RD: state_next = ST_SORT_CMP;
      ST_SORT_END: state_next = stat.pass_again ? ST_SORT_LD : ST_DONE;
      ST_DONE: state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = state == ST_IDLE;
    out_valid = state == ST_OUT;
    unique case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_INS_RD: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_KM1;
      end
      ST_INS_WR: begin
        cmd.wr = 1'b1;
        cmd.wr_sel = WR_K_RDATA;
        cmd.step = STEP_K_DEC;
      end
      ST_FETCH: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_K;
      end
      ST_GRAB: cmd.hold_sel = HOLD_RDATA;
      ST_DEL_RD: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_KP1;
      end
      ST_DEL_WR: begin
        cmd.wr = 1'b1;
        cmd.wr_sel = WR_K_RDATA;
        cmd.step = STEP_K_INC;
      end
      ST_LOC_RD: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_K;
      end
      ST_LOC_CMP: begin
        if (stat.loc_hit) begin
          cmd.fin = FIN_LOC;
        end else begin
          cmd.step = STEP_K_INC;
        end
      end
      ST_REV_RD_A: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_K;
      end
      ST_REV_RD_B: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_J;
        cmd.hold_sel = HOLD_RDATA;
      end
      ST_REV_WR_A: begin
        cmd.wr = 1'b1;
        cmd.wr_sel = WR_K_RDATA;
      end
      ST_REV_WR_B: begin
        cmd.wr = 1'b1;
        cmd.wr_sel = WR_J_HOLD;
        cmd.step = STEP_REV;
      end
      ST_SORT_LD: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_J;
      end
      ST_SORT_FIRST: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_JP1;
        cmd.hold_sel = HOLD_RDATA;
      end
      ST_SORT_CMP: begin
        cmd.wr = 1'b1;
        cmd.wr_sel = WR_J_MIN;
        cmd.hold_sel = HOLD_MAX;
        cmd.step = STEP_J_INC;
      end
      ST_SORT_RD: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = RD_JP1;
      end
      ST_SORT_END: begin
        cmd.wr = 1'b1;
        cmd.wr_sel = WR_LAST;
        cmd.step = STEP_PASS;
      end
      ST_DONE: begin
        unique case (stat.mode)
          MODE_INSERT: begin
            cmd.fin = stat.can_insert ? FIN_INS : FIN_FAIL;
            cmd.wr = stat.can_insert;
            cmd.wr_sel = WR_VAL;
          end
          MODE_DELETE: cmd.fin = stat.valid_pos ? FIN_DEL : FIN_FAIL;
          MODE_UPDATE: begin
            cmd.fin = stat.valid_pos ? FIN_OK : FIN_FAIL;
            cmd.wr = stat.valid_pos;
            cmd.wr_sel = WR_VAL;
          end
          MODE_GET: cmd.fin = stat.valid_pos ? FIN_GET : FIN_FAIL;
          MODE_LOCATE: cmd.fin = FIN_FAIL;
          MODE_LENGTH, MODE_REVERSE, MODE_SORT: cmd.fin = FIN_OK;
          MODE_CLEAR: cmd.fin = FIN_CLEAR;
          default: cmd.fin = FIN_FAIL;
        endcase
      end
      default: ;
    endcase
  end

  a_hs_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid));
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid);
  a_port_excl: assert property (@(posedge clk) disable iff (rst) !(cmd.rd && cmd.wr));
endmodule

[hdl/bounded_positional_list_engine_top.sv]
// Ordered list engine of up to 64 signed entries; each command transfer yields one result
// transfer, and the next command is taken only after that result transfer. Length, update,
// clear and unknown modes go straight to their result, and get reads one entry first. Insert,
// delete and locate move or test one entry at a time and reverse swaps one pair at a time.
// Sort runs bubble passes over the single-port memory, and result stalls add on.
module bounded_positional_list_engine_top import bple_pkg::*; (
  input logic clk,
  input logic rst,
  bple_cmd_if.sink cmd_in,
  bple_res_if.source res_out
);
  cmd_t cmd;
  stat_t stat;

  bple_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
    .out_valid(res_out.valid), .out_ready(res_out.ready), .stat(stat), .cmd(cmd)
  );

  bple_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_mode(cmd_in.mode),
    .in_position(cmd_in.position), .in_value(cmd_in.value), .res_ok(res_out.ok),
    .res_data(res_out.data), .res_index(res_out.index)
  );
endmodule

[sim/list_checker.sv]
// Checker that watches the command and result channels, predicts each result and compares it.
module list_checker import bple_pkg::*; (
  input logic clk,
  input logic rst,
  bple_cmd_if.monitor cmd_mon,
  bple_res_if.monitor res_mon,
  output int fail_count,
  output int pending
);
  typedef struct packed {
    logic ok;
    logic signed [31:0] data;
    logic [6:0] index;
  } list_result_t;

  logic signed [31:0] shadow_list [Capacity];
  int shadow_len;
  list_result_t awaited_results [$];

  function automatic list_result_t predict_list(input logic [3:0] m, input logic [7:0] p,
                                                input logic signed [31:0] v);
    list_result_t r;
    logic signed [31:0] t;
    bit located;
    int k, j;
    r = '0;
    located = 0;
    case (m)
      MODE_INSERT: begin
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < Capacity) begin
          for (k = shadow_len; k >= p; k--) shadow_list[k] = shadow_list[k - 1];
          shadow_list[p - 1] = v;
          shadow_len++;
          r.ok = 1;
        end
      end
      MODE_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          r.data = shadow_list[p - 1];
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k + 1];
          shadow_len--;
          r.ok = 1;
        end
      end
      MODE_UPDATE: begin
        if (p >= 1 && p <= shadow_len) begin
          shadow_list[p - 1] = v;
          r.ok = 1;
        end
      end
      MODE_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          r.data = shadow_list[p - 1];
          r.ok = 1;
        end
      end
      MODE_LOCATE: begin
        located = 1;
        for (k = p; k < shadow_len; k++) begin
          if (shadow_list[k] == v) begin
            r.index = 7'(k + 1);
            r.ok = 1;
            break;
          end
        end
      end
      MODE_LENGTH: r.ok = 1;
      MODE_REVERSE: begin
        for (k = 0, j = shadow_len - 1; k < j; k++, j--) begin
          t = shadow_list[k];
          shadow_list[k] = shadow_list[j];
          shadow_list[j] = t;
        end
        r.ok = 1;
      end
      MODE_SORT: begin
        for (k = shadow_len; k > 1; k--)
          for (j = 0; j + 1 < k; j++)
            if (shadow_list[j] > shadow_list[j + 1]) begin
              t = shadow_list[j];
              shadow_list[j] = shadow_list[j + 1];
              shadow_list[j + 1] = t;
            end
        r.ok = 1;
      end
      MODE_CLEAR: begin
        shadow_len = 0;
        r.ok = 1;
      end
      default: ;
    endcase
    if (!located) r.index = 7'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_len = 0;
      fail_count <= 0;
      pending <= 0;
      awaited_results.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        awaited_results.push_back(predict_list(cmd_mon.mode, cmd_mon.position,
                                               cmd_mon.value));
      if (res_mon.valid && res_mon.ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result transfer: ok=%0b data=%0d index=%0d",
                                        res_mon.ok, res_mon.data, res_mon.index);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want.ok !== res_mon.ok || want.data !== res_mon.data ||
              want.index !== res_mon.index) begin
            if (fail_count < 10)
              $display("Mismatch: expected ok=%0b data=%0d index=%0d, %s%0b data=%0d index=%0d",
                       want.ok, want.data, want.index, "got ok=", res_mon.ok, res_mon.data,
                       res_mon.index);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= awaited_results.size();
    end
  end
endmodule

[sim/tb_top.sv]
// Testbench top that drives commands and result back-pressure and gives the verdict.
module tb_top;
  import bple_pkg::*;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int live_len;

  bple_cmd_if cmd_ch ();
  bple_res_if res_ch ();

  bounded_positional_list_engine_top dut (.clk(clk), .rst(rst), .cmd_in(cmd_ch.sink),
                                          .res_out(res_ch.source));
  list_checker checker_i (.clk(clk), .rst(rst), .cmd_mon(cmd_ch.monitor),
                          .res_mon(res_ch.monitor), .fail_count(fail_count),
                          .pending(pending));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) res_ch.ready <= 0;
    else res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_cmd(input logic [3:0] m, input logic [7:0] p, input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1;
    cmd_ch.mode <= m;
    cmd_ch.position <= p;
    cmd_ch.value <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    case (m)
      MODE_INSERT: if (p >= 1 && p <= live_len + 1 && live_len < Capacity) live_len++;
      MODE_DELETE: if (p >= 1 && p <= live_len) live_len--;
      MODE_CLEAR: live_len = 0;
      default: ;
    endcase
  endtask

  task automatic random_cmd();
    int sel;
    logic [3:0] m;
    logic [7:0] p;
    logic [31:0] v;
    sel = $urandom_range(99);
    v = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(7)) - 32'd3;
    p = live_len == 0 ? 8'd1 : 8'($urandom_range(live_len + 1));
    if (sel < 30) m = MODE_INSERT;
    else if (sel < 45) m = MODE_DELETE;
    else if (sel < 55) m = MODE_UPDATE;
    else if (sel < 67) m = MODE_GET;
    else if (sel < 80) begin
      m = MODE_LOCATE;
      p = 8'($urandom_range(live_len));
    end else if (sel < 84) m = MODE_LENGTH;
    else if (sel < 89) m = MODE_REVERSE;
    else if (sel < 91) m = MODE_SORT;
    else if (sel < 92) m = MODE_CLEAR;
    else if (sel < 96) begin
      m = 4'($urandom_range(8));
      p = 8'($urandom);
    end else begin
      m = 4'($urandom_range(15, 9));
      p = 8'($urandom);
    end
    if (live_len == 0 && (m == MODE_DELETE || m == MODE_UPDATE || m == MODE_GET)) p = 8'd0;
    if (m == MODE_GET || m == MODE_DELETE || m == MODE_UPDATE)
      if (live_len > 0 && p > live_len && $urandom_range(1)) p = 8'($urandom_range(255, 65));
    send_cmd(m, p, v);
  endtask

  initial begin
    int n, k;
    rst = 1;
    live_len = 0;
    cmd_ch.valid = 0;
    cmd_ch.mode = MODE_LENGTH;
    cmd_ch.position = 0;
    cmd_ch.value = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_cmd(MODE_REVERSE, 0, 0);
    send_cmd(MODE_SORT, 0, 0);
    send_cmd(MODE_GET, 1, 0);
    send_cmd(MODE_DELETE, 0, 0);
    send_cmd(MODE_INSERT, 2, 5);
    send_cmd(MODE_INSERT, 1, 32'h7fffffff);
    send_cmd(MODE_REVERSE, 0, 0);
    send_cmd(MODE_INSERT, 1, 32'h80000000);
    send_cmd(MODE_INSERT, 3, 32'hffffffff);
    send_cmd(MODE_INSERT, 0, 1);
    send_cmd(MODE_SORT, 0, 0);
    send_cmd(MODE_GET, 1, 0);
    send_cmd(MODE_GET, 3, 0);
    send_cmd(MODE_GET, 4, 0);
    send_cmd(MODE_UPDATE, 2, 32'h7fffffff);
    send_cmd(MODE_LOCATE, 0, 32'h7fffffff);
    send_cmd(MODE_LOCATE, 2, 32'h7fffffff);
    send_cmd(MODE_LOCATE, 255, 0);
    send_cmd(MODE_REVERSE, 0, 0);
    send_cmd(MODE_DELETE, 3, 0);
    send_cmd(MODE_LENGTH, 255, 0);
    send_cmd(4'd15, 8'hff, 32'hffffffff);
    send_cmd(MODE_CLEAR, 0, 0);
    for (k = 0; k < Capacity; k++) send_cmd(MODE_INSERT, 1, $urandom);
    send_cmd(MODE_INSERT, 1, 0);
    send_cmd(MODE_SORT, 0, 0);
    send_cmd(MODE_DELETE, 64, 0);
    send_cmd(MODE_CLEAR, 0, 0);

    for (n = 0; n < 1850; n++) begin
      if (n < 620) begin
        send_idle_pct = 8;
        recv_idle_pct = 87;
      end else if (n < 1240) begin
        send_idle_pct = 87;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_cmd();
    end
    cmd_ch.valid <= 0;
    @(posedge clk);

    k = 0;
    while (pending != 0 && k < 2000000) begin
      @(posedge clk);
      k++;
    end
    repeat (200) @(posedge clk);
    if (pending == 0 && fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

[bounded_positional_list_engine_top.f]
hdl/bple_pkg.sv
hdl/bple_if.sv
hdl/bple_datapath.sv
hdl/bple_ctrl.sv
hdl/bounded_positional_list_engine_top.sv
sim/list_checker.sv
sim/tb_top.sv
